// ===== rtl/lsd_pkg.sv =====
`timescale 1ns / 1ps

package lsd_pkg;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned RootSteps = 8;

  localparam logic [19:0] RootLimit    = 20'hFC04;
  localparam logic [7:0]  RootSat      = 8'hFE;
  localparam logic [7:0]  DarkMax      = 8'hFF;
  localparam logic [14:0] RootFirstBit = 15'h4000;

  typedef struct packed {
    logic [31:0] light_three;
    logic [31:0] light_two;
    logic [31:0] light_one;
    logic [31:0] light_zero;
  } in_t;

  typedef struct packed {
    logic [63:0] colour_bytes_low;
    logic [31:0] colour_bytes_high;
    logic [31:0] intensity_bytes;
    logic [7:0]  darkness;
  } out_t;

  // Partial square root state carried between iteration stages
  typedef struct packed {
    logic        sat;
    logic [15:0] rest;
    logic [15:0] root;
  } root_t;

endpackage

// ===== rtl/lsd_lane.sv =====
`timescale 1ns / 1ps

module lsd_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] light_i,
  output logic [17:0] sum_o
);
  import lsd_pkg::*;

  logic [17:0] sum_d;
  logic [17:0] sum_q;
  logic [15:0] byte_v;

  // Sum of squares of red, green, blue and intensity of one light
  always_comb begin
    sum_d  = '0;
    byte_v = '0;
    for (int b = 0; b < 4; b++) begin
      byte_v = {8'd0, light_i[8*b +: 8]};
      sum_d  = sum_d + {2'b00, 16'(byte_v * byte_v)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/lsd_root_step.sv =====
`timescale 1ns / 1ps

module lsd_root_step (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [14:0]    bit_i,
  input  lsd_pkg::root_t d_i,
  input  lsd_pkg::in_t   lights_i,
  output lsd_pkg::root_t q_o,
  output lsd_pkg::in_t   lights_o
);
  import lsd_pkg::*;

  root_t       root_d;
  root_t       root_q;
  in_t         lights_q;
  logic [16:0] trial;

  // One restoring iteration: try to subtract root + bit from the remainder
  always_comb begin
    trial  = {1'b0, d_i.root} + {2'b00, bit_i};
    root_d = d_i;
    if ({1'b0, d_i.rest} >= trial) begin
      root_d.rest = d_i.rest - trial[15:0];
      root_d.root = (d_i.root >> 1) + {1'b0, bit_i};
    end else begin
      root_d.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q   <= root_d;
      lights_q <= lights_i;
    end
  end

  assign q_o      = root_q;
  assign lights_o = lights_q;

endmodule

// ===== rtl/led_set_darkness_from_rms_top.sv =====
`timescale 1ns / 1ps
// Stages between input transfer and output transfer: lane, merge, 8 root stages.
// Throughput: one light set per cycle unless the output stalls; each pipeline stage advances when its
// successor is free, so bubbles close up under output stall.
// The root takes one bit per stage, giving eight iteration stages.
// Reset: asynchronous active-low reset clears all stage valid bits; data is not reset.
module led_set_darkness_from_rms_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  lsd_pkg::in_t  in_i,
  output logic          valid_o,
  input  logic          stall_i,
  output lsd_pkg::out_t out_o
);
  import lsd_pkg::*;

  localparam int unsigned NumStages = RootSteps + 2;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  in_t         lights0_q;
  logic [17:0] lane_sum [LaneCount];

  in_t         lights1_q;
  root_t       root1_q;
  root_t       root1_d;
  logic [19:0] total;

  root_t       root_s   [RootSteps+1];
  in_t         lights_s [RootSteps+1];
  logic [7:0]  root_final;
  in_t         lights_last;

  // Stage enables ripple back from the output
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Lane stage: one lane per light
  lsd_lane u_lane0 (.clk_i, .en_i(en[0]), .light_i(in_i.light_zero),  .sum_o(lane_sum[0]));
  lsd_lane u_lane1 (.clk_i, .en_i(en[0]), .light_i(in_i.light_one),   .sum_o(lane_sum[1]));
  lsd_lane u_lane2 (.clk_i, .en_i(en[0]), .light_i(in_i.light_two),   .sum_o(lane_sum[2]));
  lsd_lane u_lane3 (.clk_i, .en_i(en[0]), .light_i(in_i.light_three), .sum_o(lane_sum[3]));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lights0_q <= in_i;
    end
  end

  // Merge stage: add lane sums and check saturation
  always_comb begin
    total = '0;
    for (int l = 0; l < LaneCount; l++) begin
      total = total + {2'b00, lane_sum[l]};
    end
    root1_d.sat  = (total >= RootLimit);
    root1_d.rest = total[15:0];
    root1_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      root1_q   <= root1_d;
      lights1_q <= lights0_q;
    end
  end

  assign root_s[0]   = root1_q;
  assign lights_s[0] = lights1_q;

  for (genvar i = 0; i < RootSteps; i++) begin : g_root
    lsd_root_step u_step (
      .clk_i,
      .en_i    (en[i+2]),
      .bit_i   (RootFirstBit >> (2 * i)),
      .d_i     (root_s[i]),
      .lights_i(lights_s[i]),
      .q_o     (root_s[i+1]),
      .lights_o(lights_s[i+1])
    );
  end

  assign lights_last = lights_s[RootSteps];
  assign root_final  = root_s[RootSteps].sat ? RootSat : root_s[RootSteps].root[7:0];

  assign valid_o = v_q[NumStages-1];

  always_comb begin
    out_o.colour_bytes_low  = {lights_last.light_two[15:0],
                               lights_last.light_one[23:0],
                               lights_last.light_zero[23:0]};
    out_o.colour_bytes_high = {lights_last.light_three[23:0],
                               lights_last.light_two[23:16]};
    out_o.intensity_bytes   = {lights_last.light_three[31:24],
                               lights_last.light_two[31:24],
                               lights_last.light_one[31:24],
                               lights_last.light_zero[31:24]};
    out_o.darkness          = DarkMax - root_final;
  end

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v_q == {NumStages{1'b1}}) && stall_i)
    else $error("input stalled while pipeline has room");

  a_darkness_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_o.darkness != 8'd0)
    else $error("darkness reached zero");

  a_root_below_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !root_s[RootSteps].sat) |-> root_s[RootSteps].root < 16'(RootSat))
    else $error("unsaturated root out of range");

  a_drain_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !v_q[NumStages-2]) |=> !valid_o)
    else $error("result repeated after transfer");

endmodule
